// ===== design/bertlv_pkg.sv =====
// Shared types and constants of the BER TLV primitive decoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package bertlv_pkg;

    localparam int BYTE_W     = 8;
    localparam int BLEN_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CODE_W     = 3;
    localparam int VAL_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TAG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_MODE = 1'd1;

    localparam logic [BYTE_W-1:0] TAG_RESET  = 8'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

    // content modes; any other code decodes as a counter
    localparam logic [MODE_W-1:0] MODE_INT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CNT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OID = 2'd2;

    localparam logic [BYTE_W-1:0] OID_PREFIX     = 8'h2b;
    localparam logic [VAL_W-1:0]  OID_SUB_FIRST  = 64'd1;
    localparam logic [VAL_W-1:0]  OID_SUB_SECOND = 64'd3;
    localparam logic [BYTE_W-1:0] SHORT_LEN_MAX  = 8'h7f;
    localparam logic [BLEN_W-1:0] BUFFER_MIN     = 16'd2;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_SMALL = 3'd1,
        ERR_TAG       = 3'd2,
        ERR_BUFFER    = 3'd3,
        ERR_LEN_FIELD = 3'd4,
        ERR_OID       = 3'd5
    } t_err;

    // a value record gives one result; an OID prefix record gives two (1, then 3)
    typedef enum logic {
        REC_VALUE,
        REC_OID_PREFIX
    } t_rec_kind;

    typedef struct packed {
        t_rec_kind        kind;
        t_err             code;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== design/bertlv_in_if.sv =====
// Byte input channel of the BER TLV decoder: valid/ready plus the byte fields.
// Depends on bertlv_pkg for field widths.
`timescale 1ns / 1ps

interface bertlv_in_if import bertlv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first;
    logic [BLEN_W-1:0] buffer_len;

    modport source (output valid, output data_byte, output first, output buffer_len,
                    input ready);
    modport sink   (input valid, input data_byte, input first, input buffer_len,
                    output ready);
endinterface

// ===== design/bertlv_out_if.sv =====
// Result channel of the BER TLV decoder: valid/ready plus the result fields.
// Depends on bertlv_pkg for field widths.
`timescale 1ns / 1ps

interface bertlv_out_if import bertlv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_error;
    logic [CODE_W-1:0] error_code;
    logic [VAL_W-1:0]  value;
    logic              last;

    modport source (output valid, output is_error, output error_code, output value,
                    output last, input ready);
    modport sink   (input valid, input is_error, input error_code, input value,
                    input last, output ready);
endinterface

// ===== design/bertlv_front.sv =====
// Front end: parses tag, length and content bytes and builds result records.
// Depends on bertlv_pkg.
`timescale 1ns / 1ps

module bertlv_front import bertlv_pkg::*; #(
    parameter int LENGTH_BYTES_MAX = 2,
    parameter int LENGTH_WIDTH     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first,
    input  logic [BLEN_W-1:0] i_buffer_len,
    input  logic [BYTE_W-1:0] i_expected_tag,
    input  logic [MODE_W-1:0] i_content_mode,
    output logic              o_push,
    output t_rec              o_rec
);

    localparam int LL_W  = $clog2(LENGTH_BYTES_MAX + 1);
    localparam int LW    = LENGTH_WIDTH;
    localparam int CMP_W = ((LW > BLEN_W) ? LW : BLEN_W) + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN0,
        PH_LENX,
        PH_DATA,
        PH_DONE
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [LL_W-1:0]   r_len_left, n_len_left;
    logic [LW-1:0]     r_cleft, n_cleft;
    logic [LW-1:0]     r_ctotal, n_ctotal;
    logic [BLEN_W-1:0] r_blimit, n_blimit;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic              r_oid_seen, n_oid_seen;

    logic [LW+BYTE_W-1:0] w_len_shift;
    logic [LW-1:0]        w_total;
    logic                 w_len_done;
    logic [6:0]           w_nbytes;
    logic [LW-1:0]        w_cl_dec;
    logic                 w_data_last;
    logic [31:0]          w_int_acc;
    logic [31:0]          w_int_val;
    logic [31:0]          w_oid_acc;
    logic [VAL_W-1:0]     w_cnt_acc;

    assign w_len_shift = {r_acc[LW-1:0], i_data_byte};
    assign w_nbytes    = i_data_byte[6:0];
    assign w_cl_dec    = r_cleft - LW'(1);
    assign w_data_last = (w_cl_dec == '0);
    assign w_int_acc   = {r_acc[23:0], i_data_byte};
    assign w_oid_acc   = {r_acc[24:0], i_data_byte[6:0]};
    assign w_cnt_acc   = {r_acc[VAL_W-9:0], i_data_byte};

    // sign-extend short integers from the top bit of their length
    always_comb begin
        if (r_ctotal == LW'(1)) begin
            w_int_val = {{24{w_int_acc[7]}}, w_int_acc[7:0]};
        end else if (r_ctotal == LW'(2)) begin
            w_int_val = {{16{w_int_acc[15]}}, w_int_acc[15:0]};
        end else if (r_ctotal == LW'(3)) begin
            w_int_val = {{8{w_int_acc[23]}}, w_int_acc[23:0]};
        end else begin
            w_int_val = w_int_acc;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_cleft    = r_cleft;
        n_ctotal   = r_ctotal;
        n_blimit   = r_blimit;
        n_acc      = r_acc;
        n_oid_seen = r_oid_seen;
        o_push     = 1'b0;
        o_rec      = '{kind: REC_VALUE, code: ERR_NONE, value: '0, last: 1'b1};
        w_total    = '0;
        w_len_done = 1'b0;

        if (i_accept) begin
            if (i_first) begin
                // a tag byte always restarts the parse
                n_blimit   = i_buffer_len;
                n_len_left = '0;
                n_cleft    = '0;
                n_ctotal   = '0;
                n_acc      = '0;
                n_oid_seen = 1'b0;
                if (i_buffer_len < BUFFER_MIN) begin
                    o_push     = 1'b1;
                    o_rec.code = ERR_TOO_SMALL;
                    n_phase    = PH_DONE;
                end else if (i_data_byte != i_expected_tag) begin
                    o_push     = 1'b1;
                    o_rec.code = ERR_TAG;
                    n_phase    = PH_DONE;
                end else begin
                    n_phase = PH_LEN0;
                end
            end else begin
                case (r_phase)
                    PH_LEN0: begin
                        if (i_data_byte <= SHORT_LEN_MAX) begin
                            w_total    = LW'(i_data_byte);
                            w_len_done = 1'b1;
                        end else if (w_nbytes > 7'(LENGTH_BYTES_MAX)) begin
                            o_push     = 1'b1;
                            o_rec.code = ERR_LEN_FIELD;
                            n_phase    = PH_DONE;
                        end else if (w_nbytes == '0) begin
                            w_len_done = 1'b1;
                        end else begin
                            n_len_left = LL_W'(w_nbytes);
                            n_acc      = '0;
                            n_phase    = PH_LENX;
                        end
                    end
                    PH_LENX: begin
                        n_acc      = VAL_W'(w_len_shift[LW-1:0]);
                        n_len_left = r_len_left - LL_W'(1);
                        if (r_len_left == LL_W'(1)) begin
                            w_total    = w_len_shift[LW-1:0];
                            w_len_done = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        n_cleft = w_cl_dec;
                        if (i_content_mode == MODE_INT) begin
                            n_acc = VAL_W'(w_int_acc);
                            if (w_data_last) begin
                                o_push      = 1'b1;
                                o_rec.value = {{32{w_int_val[31]}}, w_int_val};
                                n_phase     = PH_DONE;
                            end
                        end else if (i_content_mode == MODE_OID) begin
                            if (!r_oid_seen) begin
                                o_push = 1'b1;
                                if (i_data_byte != OID_PREFIX) begin
                                    o_rec.code = ERR_OID;
                                    n_phase    = PH_DONE;
                                end else begin
                                    n_oid_seen = 1'b1;
                                    n_acc      = '0;
                                    o_rec.kind = REC_OID_PREFIX;
                                    o_rec.last = w_data_last;
                                    if (w_data_last) begin
                                        n_phase = PH_DONE;
                                    end
                                end
                            end else if (!i_data_byte[7] || w_data_last) begin
                                // sub-identifier ends, or content runs out mid-way
                                o_push      = 1'b1;
                                o_rec.value = VAL_W'(w_oid_acc);
                                o_rec.last  = w_data_last;
                                n_acc       = '0;
                                if (w_data_last) begin
                                    n_phase = PH_DONE;
                                end
                            end else begin
                                n_acc = VAL_W'(w_oid_acc);
                            end
                        end else begin
                            n_acc = w_cnt_acc;
                            if (w_data_last) begin
                                o_push      = 1'b1;
                                o_rec.value = w_cnt_acc;
                                n_phase     = PH_DONE;
                            end
                        end
                    end
                    default: begin
                        // idle or finished: drop stray bytes
                    end
                endcase

                // length known: check it against the buffer and open the content
                if (w_len_done) begin
                    n_ctotal = w_total;
                    if (CMP_W'(w_total) + CMP_W'(2) > CMP_W'(r_blimit)) begin
                        o_push     = 1'b1;
                        o_rec.code = ERR_BUFFER;
                        n_phase    = PH_DONE;
                    end else begin
                        n_cleft    = w_total;
                        n_acc      = '0;
                        n_oid_seen = 1'b0;
                        if (w_total == '0) begin
                            o_push = 1'b1;
                            if (i_content_mode == MODE_OID) begin
                                o_rec.code = ERR_OID;
                            end
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_len_left <= '0;
            r_cleft    <= '0;
            r_ctotal   <= '0;
            r_blimit   <= '0;
            r_acc      <= '0;
            r_oid_seen <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_cleft    <= n_cleft;
            r_ctotal   <= n_ctotal;
            r_blimit   <= n_blimit;
            r_acc      <= n_acc;
            r_oid_seen <= n_oid_seen;
        end
    end

`ifndef SYNTH
    a_small_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_first && i_buffer_len < BUFFER_MIN)
            |-> (o_push && o_rec.code == ERR_TOO_SMALL))
        else $error("small buffer not reported");
`endif

endmodule

// ===== design/bertlv_queue.sv =====
// Short record queue between the parsing front end and the result back end.
// Depends on bertlv_pkg.
`timescale 1ns / 1ps

module bertlv_queue import bertlv_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_rec,
    input  logic   i_pop,
    output t_rec   o_rec,
    output t_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("record pushed into a full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== design/bertlv_back.sv =====
// Back end: expands queued records into results and holds the output register.
// Depends on bertlv_pkg and bertlv_out_if.
`timescale 1ns / 1ps

module bertlv_back import bertlv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qstat        i_stat,
    input  t_rec          i_rec,
    output logic          o_pop,
    bertlv_out_if.source  o_out
);

    logic              r_valid;
    logic              r_is_error;
    logic [CODE_W-1:0] r_code;
    logic [VAL_W-1:0]  r_value;
    logic              r_last;
    logic              r_pend;
    logic              r_pend_last;
    logic              w_take;

    // output register is free when empty or being taken this cycle
    assign w_take = !r_valid || o_out.ready;
    assign o_pop  = w_take && !r_pend && !i_stat.empty;

    assign o_out.valid      = r_valid;
    assign o_out.is_error   = r_is_error;
    assign o_out.error_code = r_code;
    assign o_out.value      = r_value;
    assign o_out.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else if (w_take) begin
            if (r_pend) begin
                // second half of an OID prefix
                r_valid    <= 1'b1;
                r_is_error <= 1'b0;
                r_code     <= ERR_NONE;
                r_value    <= OID_SUB_SECOND;
                r_last     <= r_pend_last;
                r_pend     <= 1'b0;
            end else if (!i_stat.empty) begin
                r_valid <= 1'b1;
                if (i_rec.kind == REC_OID_PREFIX) begin
                    r_is_error  <= 1'b0;
                    r_code      <= ERR_NONE;
                    r_value     <= OID_SUB_FIRST;
                    r_last      <= 1'b0;
                    r_pend      <= 1'b1;
                    r_pend_last <= i_rec.last;
                end else begin
                    r_is_error <= (i_rec.code != ERR_NONE);
                    r_code     <= i_rec.code;
                    r_value    <= i_rec.value;
                    r_last     <= i_rec.last;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_pend_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && r_value == OID_SUB_FIRST && !r_last))
        else $error("pending OID half without its first result");
`endif

endmodule

// ===== design/ber_tlv_primitive_decoder.sv =====
// Top level of the BER TLV primitive decoder: configuration registers and wiring.
// Depends on bertlv_pkg, bertlv_in_if, bertlv_out_if, bertlv_front, bertlv_queue, bertlv_back.
`timescale 1ns / 1ps

// Usage
//   i_in carries one byte of a BER TLV per item; first marks the tag byte and
//   buffer_len is sampled with it. o_out carries results: a decoded integer,
//   counter or OID sub-identifier, or an error report; last ends each TLV.
//   Write expected_tag (index 0) and content_mode (index 1) through i_cfg_*
//   only while the block is idle.
// Timing
//   One byte is accepted per cycle while the queue is not full. The front
//   end parses each byte in the cycle it is accepted and pushes at most one
//   record into a QUEUE_DEPTH-entry queue at that edge; the back end moves one
//   result per cycle into the output register while o_out is not stalled, and
//   a result shows on o_out once it is in that register. An OID prefix record
//   expands into two results, the second loaded after the first is taken.
// Stalls
//   When o_out is stalled the output register holds its result and the queue
//   fills; i_in.ready drops only when the queue is full.
// Reset
//   Synchronous, active low: the parser goes idle, the queue and output
//   register empty, expected_tag returns to 2 and content_mode to 0.

module ber_tlv_primitive_decoder import bertlv_pkg::*; #(
    parameter int LENGTH_BYTES_MAX = 2,
    parameter int LENGTH_WIDTH     = 16,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bertlv_in_if.sink             i_in,
    bertlv_out_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [BYTE_W-1:0] r_expected_tag;
    logic [MODE_W-1:0] r_content_mode;

    t_qstat w_qstat;
    t_rec   w_push_rec;
    t_rec   w_head_rec;
    logic   w_push;
    logic   w_pop;
    logic   w_accept;

    // take a byte whenever the queue can absorb its record
    assign i_in.ready = !w_qstat.full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_tag <= TAG_RESET;
            r_content_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPECTED_TAG: r_expected_tag <= i_cfg_data;
                CFG_CONTENT_MODE: r_content_mode <= i_cfg_data[MODE_W-1:0];
                default:          r_expected_tag <= r_expected_tag;
            endcase
        end
    end

    bertlv_front #(
        .LENGTH_BYTES_MAX (LENGTH_BYTES_MAX),
        .LENGTH_WIDTH     (LENGTH_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_data_byte    (i_in.data_byte),
        .i_first        (i_in.first),
        .i_buffer_len   (i_in.buffer_len),
        .i_expected_tag (r_expected_tag),
        .i_content_mode (r_content_mode),
        .o_push         (w_push),
        .o_rec          (w_push_rec)
    );

    bertlv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_stat  (w_qstat)
    );

    bertlv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_qstat),
        .i_rec   (w_head_rec),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== test/bertlv_decode_checker.sv =====
// Scoreboard for the BER TLV primitive decoder: watches both channels and the
// register writes, predicts every result and compares it.
// Needs bertlv_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module bertlv_decode_checker import bertlv_pkg::*; #(
    parameter int LENGTH_BYTES_MAX = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bertlv_in_if                  i_in,
    bertlv_out_if                 o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_bytes_seen,
    output int                    o_results_seen
);

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_LEN0,
        PARSE_LENX,
        PARSE_DATA,
        PARSE_DONE
    } t_parse;

    typedef struct packed {
        logic             is_error;
        t_err             code;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_result;

    t_result pending_results[$];

    t_parse             parse_state;
    logic [1:0]         len_bytes_left;
    logic [15:0]        content_left;
    logic [15:0]        content_total;
    logic [BLEN_W-1:0]  buffer_limit;
    logic [VAL_W-1:0]   acc;
    logic               oid_started;
    logic [BYTE_W-1:0]  tag_cfg;
    logic [MODE_W-1:0]  mode_cfg;

    int fails;
    int bytes_seen;
    int results_seen;

    // Sign-extend a short integer from its top content bit, then to 64 bits.
    function automatic logic [VAL_W-1:0] signed_value(input logic [31:0] raw,
                                                      input logic [15:0] len);
        logic [31:0] v;
        case (len)
            16'd1:   v = {{24{raw[7]}}, raw[7:0]};
            16'd2:   v = {{16{raw[15]}}, raw[15:0]};
            16'd3:   v = {{8{raw[23]}}, raw[23:0]};
            default: v = raw;
        endcase
        return {{32{v[31]}}, v};
    endfunction

    task automatic push_result(input t_err code, input logic [VAL_W-1:0] val,
                               input logic last);
        t_result r;
        r.is_error = (code != ERR_NONE);
        r.code     = code;
        r.value    = val;
        r.last     = last;
        pending_results = {pending_results, r};
    endtask

    task automatic abort_tlv(input t_err code);
        push_result(code, '0, 1'b1);
        parse_state = PARSE_DONE;
    endtask

    // Length is known: check it against the buffer and open the content.
    task automatic open_content();
        if ({1'b0, content_total} + 17'd2 > {1'b0, buffer_limit}) begin
            abort_tlv(ERR_BUFFER);
        end else begin
            content_left = content_total;
            acc          = '0;
            oid_started  = 1'b0;
            if (content_total == 16'd0) begin
                if (mode_cfg == MODE_OID) begin
                    abort_tlv(ERR_OID);
                end else begin
                    push_result(ERR_NONE, '0, 1'b1);
                    parse_state = PARSE_DONE;
                end
            end else begin
                parse_state = PARSE_DATA;
            end
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic first_flag,
                               input logic [BLEN_W-1:0] blen);
        logic [6:0] n_len;
        if (first_flag) begin
            buffer_limit   = blen;
            len_bytes_left = '0;
            content_left   = '0;
            content_total  = '0;
            acc            = '0;
            oid_started    = 1'b0;
            if (blen < BUFFER_MIN) begin
                abort_tlv(ERR_TOO_SMALL);
            end else if (b != tag_cfg) begin
                abort_tlv(ERR_TAG);
            end else begin
                parse_state = PARSE_LEN0;
            end
        end else begin
            case (parse_state)
                PARSE_LEN0: begin
                    n_len = b[6:0];
                    if (b <= SHORT_LEN_MAX) begin
                        content_total = {8'd0, b};
                        open_content();
                    end else if (n_len > LENGTH_BYTES_MAX) begin
                        abort_tlv(ERR_LEN_FIELD);
                    end else if (n_len == 7'd0) begin
                        content_total = '0;
                        open_content();
                    end else begin
                        len_bytes_left = n_len[1:0];
                        acc            = '0;
                        parse_state    = PARSE_LENX;
                    end
                end
                PARSE_LENX: begin
                    acc            = {48'd0, acc[7:0], b};
                    len_bytes_left = len_bytes_left - 2'd1;
                    if (len_bytes_left == 2'd0) begin
                        content_total = acc[15:0];
                        open_content();
                    end
                end
                PARSE_DATA: begin
                    content_left = content_left - 16'd1;
                    if (mode_cfg == MODE_INT) begin
                        acc = {32'd0, acc[23:0], b};
                        if (content_left == 16'd0) begin
                            push_result(ERR_NONE, signed_value(acc[31:0], content_total), 1'b1);
                            parse_state = PARSE_DONE;
                        end
                    end else if (mode_cfg == MODE_OID) begin
                        if (!oid_started) begin
                            if (b != OID_PREFIX) begin
                                abort_tlv(ERR_OID);
                            end else begin
                                oid_started = 1'b1;
                                acc         = '0;
                                push_result(ERR_NONE, OID_SUB_FIRST, 1'b0);
                                push_result(ERR_NONE, OID_SUB_SECOND, content_left == 16'd0);
                                if (content_left == 16'd0)
                                    parse_state = PARSE_DONE;
                            end
                        end else begin
                            acc = {32'd0, acc[24:0], b[6:0]};
                            // a clear top bit ends a sub-identifier; so does the content end
                            if (!b[7] || content_left == 16'd0) begin
                                push_result(ERR_NONE, acc, content_left == 16'd0);
                                acc = '0;
                                if (content_left == 16'd0)
                                    parse_state = PARSE_DONE;
                            end
                        end
                    end else begin
                        acc = {acc[55:0], b};
                        if (content_left == 16'd0) begin
                            push_result(ERR_NONE, acc, 1'b1);
                            parse_state = PARSE_DONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_result();
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            $error("result with nothing expected: is_error %0d code %0d value %h last %0d",
                   o_out.is_error, o_out.error_code, o_out.value, o_out.last);
            fails++;
        end else begin
            want = pending_results.pop_front();
            if (o_out.is_error !== want.is_error) begin
                $error("is_error mismatch: expected %0d, actual %0d", want.is_error,
                       o_out.is_error);
                fails++;
            end
            if (o_out.error_code !== want.code) begin
                $error("error_code mismatch: expected %0d, actual %0d", want.code,
                       o_out.error_code);
                fails++;
            end
            if (o_out.value !== want.value) begin
                $error("value mismatch: expected %h, actual %h", want.value, o_out.value);
                fails++;
            end
            if (o_out.last !== want.last) begin
                $error("last mismatch: expected %0d, actual %0d", want.last, o_out.last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_results.delete();
            parse_state    = PARSE_IDLE;
            len_bytes_left = '0;
            content_left   = '0;
            content_total  = '0;
            buffer_limit   = '0;
            acc            = '0;
            oid_started    = 1'b0;
            tag_cfg        = TAG_RESET;
            mode_cfg       = MODE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXPECTED_TAG: tag_cfg  = i_cfg_data;
                    CFG_CONTENT_MODE: mode_cfg = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            // a result never belongs to the byte taken at the same edge
            if (o_out.valid && o_out.ready)
                check_result();
            if (i_in.valid && i_in.ready) begin
                bytes_seen++;
                decode_byte(i_in.data_byte, i_in.first, i_in.buffer_len);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= pending_results.size();
        o_bytes_seen   <= bytes_seen;
        o_results_seen <= results_seen;
    end

endmodule

// ===== test/ber_tlv_primitive_decoder_test.sv =====
// Top of the BER TLV decoder testbench: clock, reset, byte stimulus, result
// stalls and register phases.
// Needs bertlv_pkg, the channel interfaces and bertlv_decode_checker.
`timescale 1ns / 1ps

module ber_tlv_primitive_decoder_test;
    import bertlv_pkg::*;

    localparam int TIMEOUT_NS          = 2_000_000;
    localparam int RESET_CYCLES        = 2;
    localparam int SETTLE_CYCLES       = 8;    // pipeline plus output register, with margin
    localparam int IDLE_PCT            = 17;
    localparam int BYTES_PER_PHASE     = 215;
    localparam int LENGTH_BYTES_MAX_TB = 2;

    // spare mode code; the block decodes it as a counter
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bertlv_in_if  in_ch ();
    bertlv_out_if out_ch ();

    int fail_count;
    int pending;
    int bytes_seen;
    int results_seen;

    // current register contents, so well-formed TLVs carry the right tag
    logic [BYTE_W-1:0] cur_tag;
    logic [MODE_W-1:0] cur_mode;

    // when set, neither side idles
    bit quiet = 1'b0;

    logic [BYTE_W-1:0] tlv_bytes[$];
    logic [BYTE_W-1:0] content_bytes[$];
    int                bytes_queued = 0;
    int                settings_used = 1;

    ber_tlv_primitive_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    bertlv_decode_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .o_out          (out_ch),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bytes_seen   (bytes_seen),
        .o_results_seen (results_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: stall at random, except in the quiet stretch.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Append one byte to the TLV being built.
    task automatic add_tlv_byte(input logic [BYTE_W-1:0] b);
        tlv_bytes = {tlv_bytes, b};
    endtask

    // Append one byte to the content being built.
    task automatic add_content_byte(input logic [BYTE_W-1:0] b);
        content_bytes = {content_bytes, b};
    endtask

    // Mostly random content, with the boundary values weighted up.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Present one item and hold it until the block takes it. An idle gap, if
    // any, comes before the item so valid is never dropped and raised in one step.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first_flag,
                             input logic [BLEN_W-1:0] blen);
        int gap;
        if (!quiet && $urandom_range(99) < IDLE_PCT - 3) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(2, 6) : 1;
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first      <= first_flag;
        in_ch.buffer_len <= blen;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Send tlv_bytes: the tag with the buffer length, the rest with junk lengths.
    task automatic send_tlv(input logic [BLEN_W-1:0] blen);
        foreach (tlv_bytes[i])
            send_byte(tlv_bytes[i], i == 0, (i == 0) ? blen : BLEN_W'($urandom_range(65535)));
        bytes_queued += tlv_bytes.size();
    endtask

    // Drop valid and wait for every expected result plus the pipeline tail.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Close any open TLV with a too-small report, drain, then write both registers.
    task automatic set_config(input logic [BYTE_W-1:0] tag, input logic [MODE_W-1:0] mode);
        send_byte(8'h00, 1'b1, 16'd0);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_EXPECTED_TAG;
        i_cfg_data <= tag;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CONTENT_MODE;
        i_cfg_data <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_tag  = tag;
        cur_mode = mode;
        settings_used++;
    endtask

    task automatic build_oid_content();
        int subs;
        int nb;
        // now and then leave the content empty, or break the prefix
        if ($urandom_range(19) != 0) begin
            add_content_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : OID_PREFIX);
            subs = $urandom_range(0, 5);
            repeat (subs) begin
                nb = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
                repeat (nb - 1) add_content_byte({1'b1, 7'($urandom_range(127))});
                add_content_byte({1'b0, 7'($urandom_range(127))});
            end
            // unterminated trailing sub-identifier
            if ($urandom_range(99) < 15)
                add_content_byte({1'b1, 7'($urandom_range(127))});
        end
    endtask

    // One random TLV: mostly well formed, the rest noise, bad length fields,
    // huge lengths, wrong tags, short buffers, truncation and trailing bytes.
    task automatic random_tlv();
        int                r;
        int                n;
        int                cut;
        logic [15:0]       big;
        logic [BLEN_W-1:0] blen;
        r = $urandom_range(99);
        tlv_bytes.delete();
        content_bytes.delete();
        if (r < 6) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(255)), 1'b0, BLEN_W'($urandom_range(65535)));
            return;
        end
        add_tlv_byte(($urandom_range(99) < 6) ? 8'($urandom_range(255)) : cur_tag);
        if (r < 10) begin
            add_tlv_byte(8'h80 | 8'($urandom_range(LENGTH_BYTES_MAX_TB + 1, 127)));
            add_tlv_byte(pick_byte());
            send_tlv(BLEN_W'($urandom_range(65535)));
            return;
        end
        if (r < 13) begin
            // long content that is abandoned by the next tag
            big = 16'($urandom_range(256, 65535));
            add_tlv_byte(8'h82);
            add_tlv_byte(big[15:8]);
            add_tlv_byte(big[7:0]);
            repeat ($urandom_range(0, 4)) add_tlv_byte(pick_byte());
            send_tlv($urandom_range(1) ? 16'hFFFF : BLEN_W'($urandom_range(65535)));
            return;
        end
        if (cur_mode == MODE_OID) begin
            build_oid_content();
        end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
            repeat (n) add_content_byte(pick_byte());
        end
        n = content_bytes.size();
        r = $urandom_range(99);
        if (n == 0 && r < 15) begin
            add_tlv_byte(8'h80);
        end else if (n <= 127 && r < 60) begin
            add_tlv_byte(8'(n));
        end else if (n <= 255 && r < 80) begin
            add_tlv_byte(8'h81);
            add_tlv_byte(8'(n));
        end else begin
            add_tlv_byte(8'h82);
            add_tlv_byte(8'(n >> 8));
            add_tlv_byte(8'(n));
        end
        foreach (content_bytes[i]) add_tlv_byte(content_bytes[i]);
        r = $urandom_range(99);
        if (r < 78)
            blen = BLEN_W'(n + 2 + $urandom_range(0, 20));
        else if (r < 88)
            blen = BLEN_W'(n + 1);
        else if (r < 94)
            blen = BLEN_W'($urandom_range(0, 1));
        else
            blen = BLEN_W'($urandom_range(65535));
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, 3)) add_tlv_byte(pick_byte());
        if ($urandom_range(99) < 8 && tlv_bytes.size() > 1) begin
            cut = $urandom_range(0, tlv_bytes.size() - 2);
            while (tlv_bytes.size() > cut + 1) void'(tlv_bytes.pop_back());
        end
        send_tlv(blen);
    endtask

    task automatic random_phase(input int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target) random_tlv();
    endtask

    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= '0;
        in_ch.first      <= 1'b0;
        in_ch.buffer_len <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_EXPECTED_TAG;
        i_cfg_data       <= '0;
        i_rst_n          <= 1'b0;
        cur_tag  = TAG_RESET;
        cur_mode = MODE_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Integer mode at the reset settings.
        send_byte(8'h55, 1'b0, 16'hFFFF);                  // stray byte while idle
        tlv_bytes = '{8'h07};                              // small buffer beats the tag check
        send_tlv(16'd0);
        tlv_bytes = '{8'h03};                              // tag mismatch
        send_tlv(16'd300);
        tlv_bytes = '{TAG_RESET, 8'h01, 8'h80};            // one byte, negative
        send_tlv(16'd3);
        tlv_bytes = '{TAG_RESET, 8'h80};                   // long form with no length bytes
        send_tlv(16'd2);
        tlv_bytes = '{TAG_RESET, 8'h83};                   // too many length bytes
        send_tlv(16'd50);
        tlv_bytes = '{TAG_RESET, 8'h04};                   // content exceeds the buffer
        send_tlv(16'd5);
        tlv_bytes = '{TAG_RESET, 8'h82, 8'hFF, 8'hFD};     // fits, then cut off by a new tag
        send_tlv(16'hFFFF);
        // five bytes keep the low 32 bits; the byte after the content is dropped
        tlv_bytes = '{TAG_RESET, 8'h05, 8'h11, 8'h80, 8'h00, 8'h00, 8'h01, 8'h77};
        send_tlv(16'd7);
        random_phase(BYTES_PER_PHASE);

        set_config(8'h06, MODE_OID);
        tlv_bytes = '{8'h06, 8'h00};                       // empty OID lacks the prefix
        send_tlv(16'd2);
        tlv_bytes = '{8'h06, 8'h03, OID_PREFIX, 8'h81, 8'h81};  // unterminated tail
        send_tlv(16'd5);
        random_phase(BYTES_PER_PHASE);

        set_config(8'h00, MODE_CNT);
        random_phase(BYTES_PER_PHASE);

        // long stretch with no idling on either side
        set_config(8'hFF, MODE_SPARE);
        quiet = 1'b1;
        random_phase(BYTES_PER_PHASE);
        quiet = 1'b0;

        set_config(8'h41, MODE_OID);
        random_phase(BYTES_PER_PHASE);

        set_config(8'h02, MODE_INT);
        random_phase(BYTES_PER_PHASE);

        set_config(8'hAA, MODE_CNT);
        random_phase(BYTES_PER_PHASE);

        wait_idle();

        $display("Run covered %0d input bytes and %0d checked results", bytes_seen,
                 results_seen);
        $display("over %0d register settings, all content modes and every error code",
                 settings_used);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
